### hw/rtl/efb_pfs_pkg.sv
// Shared types, codes and color quantization helpers of the framebuffer store.
package efb_pfs_pkg;

    localparam int COORD_BITS = 10;
    localparam int COLOR_BITS = 8;
    localparam int DEPTH_BITS = 24;
    localparam int FMT_BITS   = 3;
    localparam int STAT_BITS  = 2;
    // Row index times width plus column, wide enough for a 1024 by 1024 frame.
    localparam int PROD_BITS  = 2 * COORD_BITS + 1;

    localparam logic [FMT_BITS-1:0] FMT_RGB8_Z24   = 3'd0;
    localparam logic [FMT_BITS-1:0] FMT_RGBA6_Z24  = 3'd1;
    localparam logic [FMT_BITS-1:0] FMT_RGB565_Z16 = 3'd2;
    localparam logic [FMT_BITS-1:0] FMT_Z24        = 3'd3;

    localparam logic [STAT_BITS-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_UNSUP = 2'd2;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef struct packed {
        logic                  req_type;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [COLOR_BITS-1:0] red_in;
        logic [COLOR_BITS-1:0] green_in;
        logic [COLOR_BITS-1:0] blue_in;
        logic [DEPTH_BITS-1:0] depth_in;
    } t_efb_in;

    typedef struct packed {
        logic [DEPTH_BITS-1:0] depth_out;
        logic [STAT_BITS-1:0]  status;
    } t_efb_out;

    // Keep the top six bits and repeat their top two below them.
    function automatic logic [COLOR_BITS-1:0] quant6(input logic [COLOR_BITS-1:0] v);
        return {v[7:2], v[7:6]};
    endfunction

    // Keep the top five bits and repeat their top three below them.
    function automatic logic [COLOR_BITS-1:0] quant5(input logic [COLOR_BITS-1:0] v);
        return {v[7:3], v[7:5]};
    endfunction

endpackage

### hw/rtl/efb_pixel_format_store_top.sv
// Top level of the embedded framebuffer store: pipeline, memories and format logic.

// The block takes one word per clock cycle, a pixel write or a depth read, and
// returns one result word per input word, in order. A word passes three registers
// (input register, registered memory read, output register) before its result
// word is valid at the output. The rate is set by the single access port of each
// framebuffer memory: every word touches exactly one entry, so one word per cycle
// is sustained as long as the output side does not stall.
// Coordinates outside the active area (column at or above FB_WIDTH, row at or
// above FB_HEIGHT, or FB_HEIGHT_HALF in the RGB565_Z16 format) are ignored and
// answered with depth 0 and status "out of range". The memories have no reset
// and no clearing pass: reading a pixel that was never written returns whatever
// the memory holds. The pixel format register may only be written while no word
// is in flight.
module efb_pixel_format_store_top #(
    parameter int FB_WIDTH       = 640,
    parameter int FB_HEIGHT      = 528,
    parameter int FB_HEIGHT_HALF = 264
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  efb_pfs_pkg::t_efb_in                i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output efb_pfs_pkg::t_efb_out               o_out_word,
    input  logic                                i_cfg_we,
    input  logic [efb_pfs_pkg::FMT_BITS-1:0]    i_cfg_wdata
);

    localparam int ROWS_MAX   = (FB_HEIGHT > FB_HEIGHT_HALF) ? FB_HEIGHT : FB_HEIGHT_HALF;
    localparam int STORE_SIZE = FB_WIDTH * ROWS_MAX;
    localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int CMP_W      = efb_pfs_pkg::COORD_BITS + 1;

    localparam int CW = efb_pfs_pkg::COLOR_BITS;
    localparam int DW = efb_pfs_pkg::DEPTH_BITS;

    // Pixel format register.
    logic [efb_pfs_pkg::FMT_BITS-1:0] r_pixel_format;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format <= efb_pfs_pkg::FMT_RGB8_Z24;
        end else if (i_cfg_we) begin
            r_pixel_format <= i_cfg_wdata;
        end
    end

    // Pipeline flow control. Each stage advances when the one after it is empty
    // or moving, so bubbles are squeezed out and a stalled result does not block
    // words further up until the whole pipeline is full.
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_out_valid;
    logic en_out;
    logic en2;
    logic en1;

    assign en_out     = !r_out_valid || !i_out_stall;
    assign en2        = !r_s2_valid || en_out;
    assign en1        = !r_s1_valid || en2;
    assign o_in_stall = !en1;

    // Stage one: the input register.
    efb_pfs_pkg::t_efb_in r_s1_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en1) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_in_valid) begin
            r_s1_word <= i_in_word;
        end
    end

    // Range check, address and write data for the word in stage one.
    logic                                  fmt_z16;
    logic                                  fmt_unsup;
    logic                                  in_range;
    logic [efb_pfs_pkg::PROD_BITS-1:0]     addr_full;
    logic [ADDR_W-1:0]                     addr;
    logic                                  depth_we;
    logic                                  colour_we;
    logic [3*CW-1:0]                       colour_wdata;
    logic [DW-1:0]                         depth_wdata;
    logic [efb_pfs_pkg::STAT_BITS-1:0]     status1;

    assign fmt_z16   = (r_pixel_format == efb_pfs_pkg::FMT_RGB565_Z16);
    assign fmt_unsup = (r_pixel_format > efb_pfs_pkg::FMT_Z24);

    always_comb begin
        in_range = (CMP_W'(r_s1_word.pos_x) < CMP_W'(FB_WIDTH));
        if (fmt_z16) begin
            in_range = in_range && (CMP_W'(r_s1_word.pos_y) < CMP_W'(FB_HEIGHT_HALF));
        end else begin
            in_range = in_range && (CMP_W'(r_s1_word.pos_y) < CMP_W'(FB_HEIGHT));
        end
    end

    assign addr_full = efb_pfs_pkg::PROD_BITS'(r_s1_word.pos_y)
                     * efb_pfs_pkg::PROD_BITS'(FB_WIDTH)
                     + efb_pfs_pkg::PROD_BITS'(r_s1_word.pos_x);
    // Rejected words still drive the read port; keep that address inside the array.
    assign addr = in_range ? addr_full[ADDR_W-1:0] : '0;

    always_comb begin
        colour_wdata = {r_s1_word.red_in, r_s1_word.green_in, r_s1_word.blue_in};
        depth_wdata  = r_s1_word.depth_in;
        case (r_pixel_format)
            efb_pfs_pkg::FMT_RGB8_Z24: begin
            end
            efb_pfs_pkg::FMT_RGBA6_Z24: begin
                colour_wdata = {efb_pfs_pkg::quant6(r_s1_word.red_in),
                                efb_pfs_pkg::quant6(r_s1_word.green_in),
                                efb_pfs_pkg::quant6(r_s1_word.blue_in)};
            end
            efb_pfs_pkg::FMT_RGB565_Z16: begin
                colour_wdata = {efb_pfs_pkg::quant5(r_s1_word.red_in),
                                efb_pfs_pkg::quant6(r_s1_word.green_in),
                                efb_pfs_pkg::quant5(r_s1_word.blue_in)};
                depth_wdata  = {r_s1_word.depth_in[DW-1:CW], {CW{1'b0}}};
            end
            default: begin
            end
        endcase
    end

    // Z24 updates depth only; the YUV formats write nothing.
    assign depth_we  = en2 && r_s1_valid && in_range
                    && (r_s1_word.req_type == efb_pfs_pkg::REQ_WRITE) && !fmt_unsup;
    assign colour_we = depth_we && (r_pixel_format != efb_pfs_pkg::FMT_Z24);

    always_comb begin
        if (!in_range) begin
            status1 = efb_pfs_pkg::ST_RANGE;
        end else if (fmt_unsup) begin
            status1 = efb_pfs_pkg::ST_UNSUP;
        end else begin
            status1 = efb_pfs_pkg::ST_DONE;
        end
    end

    // Framebuffer memories, one access per cycle each.
    logic [3*CW-1:0] colour_mem [STORE_SIZE];
    logic [DW-1:0]   depth_mem  [STORE_SIZE];

    always_ff @(posedge i_clk) begin
        if (colour_we) begin
            colour_mem[addr] <= colour_wdata;
        end
    end

    // Stage two: registered depth read plus the flags the output stage needs.
    logic [DW-1:0]                     r_s2_rdata;
    logic                              r_s2_rd;
    logic [efb_pfs_pkg::STAT_BITS-1:0] r_s2_status;

    always_ff @(posedge i_clk) begin
        if (depth_we) begin
            depth_mem[addr] <= depth_wdata;
        end
        if (en2) begin
            r_s2_rdata <= depth_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_rd     <= in_range && (r_s1_word.req_type == efb_pfs_pkg::REQ_READ);
            r_s2_status <= status1;
        end
    end

    // Output stage: shape the read depth and register the result word.
    efb_pfs_pkg::t_efb_out r_out_word;
    logic [DW-1:0]         depth_res;

    always_comb begin
        if (!r_s2_rd) begin
            depth_res = '0;
        end else if (fmt_z16) begin
            // Upper 16 bits of the stored depth with the high byte repeated below.
            depth_res = {r_s2_rdata[DW-1:CW], r_s2_rdata[DW-1:DW-CW]};
        end else begin
            depth_res = r_s2_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_s2_valid) begin
            r_out_word.depth_out <= depth_res;
            r_out_word.status    <= r_s2_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // The input side is only held off when every stage holds a word.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_s2_valid && r_out_valid))
        else $error("input stalled while the pipeline has a free stage");

    // No memory write may happen in one of the unsupported formats.
    a_no_write_unsup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (depth_we || colour_we) |-> !fmt_unsup)
        else $error("framebuffer written in an unsupported format");

    // A rejected coordinate always comes back with zero depth.
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_word.status == efb_pfs_pkg::ST_RANGE))
            |-> (r_out_word.depth_out == '0))
        else $error("out-of-range result carries a nonzero depth");

endmodule

### sim/tb.sv
// Self-checking testbench for the embedded framebuffer store with pixel formats.
`timescale 1ns / 100ps

module tb;

    // Frame geometry used by the testbench predictor and passed to the block.
    localparam int FB_W      = 640;
    localparam int FB_H      = 528;
    localparam int FB_H_HALF = 264;
    localparam int COORD_MAX = (1 << efb_pfs_pkg::COORD_BITS) - 1;

    // The package names only the implemented formats; the four YUV codes above
    // them are unsupported but still legal register values.
    localparam logic [efb_pfs_pkg::FMT_BITS-1:0] FMT_YUV4 = 3'd4;
    localparam logic [efb_pfs_pkg::FMT_BITS-1:0] FMT_YUV5 = 3'd5;
    localparam logic [efb_pfs_pkg::FMT_BITS-1:0] FMT_YUV6 = 3'd6;
    localparam logic [efb_pfs_pkg::FMT_BITS-1:0] FMT_YUV7 = 3'd7;

    // Effective words (stored writes plus in-frame reads) per random phase.
    localparam int PHASE_WORDS = 41;

    logic                             clk         = 1'b0;
    logic                             rst_n       = 1'b0;
    logic                             in_valid    = 1'b0;
    logic                             in_stall;
    efb_pfs_pkg::t_efb_in             in_word     = '0;
    logic                             out_valid;
    logic                             out_stall   = 1'b0;
    efb_pfs_pkg::t_efb_out            out_word;
    logic                             cfg_we      = 1'b0;
    logic [efb_pfs_pkg::FMT_BITS-1:0] cfg_wdata   = '0;

    // Testbench copy of the block state. Only pixels present in depth_mem are
    // ever read back, since the frame memories come up undefined.
    logic [efb_pfs_pkg::FMT_BITS-1:0]   fmt_cfg = efb_pfs_pkg::FMT_RGB8_Z24;
    logic [efb_pfs_pkg::DEPTH_BITS-1:0] depth_mem[int unsigned];
    logic [23:0]                        colour_mem[int unsigned];
    int unsigned                        written_px[$];

    // Expected answers, one per word sent, oldest first.
    efb_pfs_pkg::t_efb_out answer_q[$];

    // Sender and receiver idling controls.
    bit          sender_idles   = 1'b1;
    bit          receiver_idles = 1'b1;
    int unsigned burst_left     = 0;
    int unsigned stall_span     = 0;
    int unsigned stall_pct      = 0;

    // Bookkeeping for the final report.
    int unsigned errors         = 0;
    int unsigned results_seen   = 0;
    int unsigned stored_words   = 0;
    int unsigned read_words     = 0;
    int unsigned outside_words  = 0;
    int unsigned dropped_writes = 0;
    int unsigned format_writes  = 0;

    efb_pixel_format_store_top #(
        .FB_WIDTH       (FB_W),
        .FB_HEIGHT      (FB_H),
        .FB_HEIGHT_HALF (FB_H_HALF)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // 8 ns clock period.
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The run is cut off as a failure, far beyond what the slowest run needs.
    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver stall pattern: after each span of random length a new stall density is chosen,
    // from never stalling to stalling almost every cycle.
    always @(posedge clk) begin
        if (stall_span == 0) begin
            stall_span <= $urandom_range(8, 48);
            case ($urandom_range(0, 3))
                0:       stall_pct <= 0;
                1:       stall_pct <= 25;
                2:       stall_pct <= 60;
                default: stall_pct <= 90;
            endcase
        end else begin
            stall_span <= stall_span - 1;
        end
        out_stall <= receiver_idles && ($urandom_range(0, 99) < stall_pct);
    end

    // Keep the top bits of a color channel and repeat their upper bits below them.
    function automatic logic [efb_pfs_pkg::COLOR_BITS-1:0] trim_channel(
        input logic [efb_pfs_pkg::COLOR_BITS-1:0] v,
        input int bits);
        logic [efb_pfs_pkg::COLOR_BITS-1:0] top;
        top = v >> (efb_pfs_pkg::COLOR_BITS - bits);
        return (top << (efb_pfs_pkg::COLOR_BITS - bits))
             | (top >> (2 * bits - efb_pfs_pkg::COLOR_BITS));
    endfunction

    // Works out the answer to one word and applies its effect on the stored frame.
    // Coordinates are checked first, so an out-of-frame word reports a range error
    // even under an unsupported format.
    function automatic efb_pfs_pkg::t_efb_out predict_access(input efb_pfs_pkg::t_efb_in w);
        efb_pfs_pkg::t_efb_out              r;
        int unsigned                        rows;
        int unsigned                        px;
        logic [efb_pfs_pkg::DEPTH_BITS-1:0] z;
        r    = '0;
        r.status = efb_pfs_pkg::ST_DONE;
        rows = (fmt_cfg == efb_pfs_pkg::FMT_RGB565_Z16) ? FB_H_HALF : FB_H;
        if (w.pos_x >= FB_W || w.pos_y >= rows) begin
            r.status = efb_pfs_pkg::ST_RANGE;
            outside_words++;
            return r;
        end
        px = w.pos_y * FB_W + w.pos_x;
        if (w.req_type == efb_pfs_pkg::REQ_WRITE) begin
            case (fmt_cfg)
                efb_pfs_pkg::FMT_RGB8_Z24: begin
                    colour_mem[px] = {w.red_in, w.green_in, w.blue_in};
                    z = w.depth_in;
                end
                efb_pfs_pkg::FMT_RGBA6_Z24: begin
                    colour_mem[px] = {trim_channel(w.red_in, 6), trim_channel(w.green_in, 6),
                                      trim_channel(w.blue_in, 6)};
                    z = w.depth_in;
                end
                efb_pfs_pkg::FMT_RGB565_Z16: begin
                    colour_mem[px] = {trim_channel(w.red_in, 5), trim_channel(w.green_in, 6),
                                      trim_channel(w.blue_in, 5)};
                    z = {w.depth_in[23:8], 8'h00};
                end
                efb_pfs_pkg::FMT_Z24: begin
                    // Depth only; the stored color stays as it was.
                    z = w.depth_in;
                end
                default: begin
                    r.status = efb_pfs_pkg::ST_UNSUP;
                end
            endcase
            if (r.status == efb_pfs_pkg::ST_DONE) begin
                if (!depth_mem.exists(px))
                    written_px.push_back(px);
                depth_mem[px] = z;
                stored_words++;
            end else begin
                dropped_writes++;
            end
        end else begin
            z = depth_mem[px];
            read_words++;
            if (fmt_cfg == efb_pfs_pkg::FMT_RGB565_Z16) begin
                // 16-bit depth: upper 16 bits, with the high byte repeated below.
                r.depth_out = {z[23:8], z[23:16]};
            end else begin
                r.depth_out = z;
                if (fmt_cfg > efb_pfs_pkg::FMT_Z24)
                    r.status = efb_pfs_pkg::ST_UNSUP;
            end
        end
        return r;
    endfunction

    // Picks a pixel that has been written, preferring one inside the active rows.
    function automatic int unsigned pick_written(input int unsigned rows);
        int unsigned px;
        px = written_px[$urandom_range(0, written_px.size() - 1)];
        for (int n = 0; n < 4 && px / FB_W >= rows; n++)
            px = written_px[$urandom_range(0, written_px.size() - 1)];
        return px;
    endfunction

    // Builds one random word for the current format. Most words are writes into
    // the frame or reads of pixels already written; some fall outside the frame.
    function automatic efb_pfs_pkg::t_efb_in random_access();
        efb_pfs_pkg::t_efb_in w;
        int unsigned          rows;
        int unsigned          roll;
        int unsigned          px;
        rows       = (fmt_cfg == efb_pfs_pkg::FMT_RGB565_Z16) ? FB_H_HALF : FB_H;
        roll       = $urandom_range(0, 99);
        w.red_in   = efb_pfs_pkg::COLOR_BITS'($urandom);
        w.green_in = efb_pfs_pkg::COLOR_BITS'($urandom);
        w.blue_in  = efb_pfs_pkg::COLOR_BITS'($urandom);
        w.depth_in = efb_pfs_pkg::DEPTH_BITS'($urandom);
        if (roll < 12) begin
            w.req_type = 1'($urandom);
            if ($urandom_range(0, 1) == 0) begin
                w.pos_x = efb_pfs_pkg::COORD_BITS'($urandom_range(FB_W, COORD_MAX));
                w.pos_y = efb_pfs_pkg::COORD_BITS'($urandom);
            end else begin
                w.pos_x = efb_pfs_pkg::COORD_BITS'($urandom);
                w.pos_y = efb_pfs_pkg::COORD_BITS'($urandom_range(rows, COORD_MAX));
            end
            return w;
        end
        if (roll < 55) begin
            w.req_type = efb_pfs_pkg::REQ_WRITE;
            // A quarter of the writes land on a pixel that already holds data.
            if ($urandom_range(0, 3) == 0)
                px = pick_written(rows);
            else
                px = $urandom_range(0, rows - 1) * FB_W + $urandom_range(0, FB_W - 1);
            if (px / FB_W >= rows)
                px = px % FB_W;
        end else begin
            w.req_type = efb_pfs_pkg::REQ_READ;
            px = pick_written(rows);
        end
        w.pos_x = efb_pfs_pkg::COORD_BITS'(px % FB_W);
        w.pos_y = efb_pfs_pkg::COORD_BITS'(px / FB_W);
        return w;
    endfunction

    // Offers one word and returns at the edge that accepts it, leaving valid high
    // so that a following word can go out back to back. When a burst runs out,
    // valid drops for a random gap first.
    task automatic send_word(input efb_pfs_pkg::t_efb_in w);
        answer_q.push_back(predict_access(w));
        in_word  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (sender_idles) begin
            if (burst_left == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                burst_left = $urandom_range(1, 20);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_access(input logic req, input int unsigned x, input int unsigned y,
                               input logic [23:0] rgb,
                               input logic [efb_pfs_pkg::DEPTH_BITS-1:0] z);
        efb_pfs_pkg::t_efb_in w;
        w.req_type = req;
        w.pos_x    = efb_pfs_pkg::COORD_BITS'(x);
        w.pos_y    = efb_pfs_pkg::COORD_BITS'(y);
        w.red_in   = rgb[23:16];
        w.green_in = rgb[15:8];
        w.blue_in  = rgb[7:0];
        w.depth_in = z;
        send_word(w);
    endtask

    // Drops valid and waits until every expected answer has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
    endtask

    // The format register is only written with nothing in flight. Every word
    // produces an answer, so an empty answer queue means an empty pipeline.
    task automatic set_format(input logic [efb_pfs_pkg::FMT_BITS-1:0] f);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= f;
        @(posedge clk);
        cfg_we  <= 1'b0;
        fmt_cfg = f;
        format_writes++;
    endtask

    // Format after reset: frame corners, extreme values and the range limits.
    task automatic test_reset_format();
        send_access(efb_pfs_pkg::REQ_WRITE, 0, 0, 24'h000000, 24'h000000);
        send_access(efb_pfs_pkg::REQ_WRITE, FB_W - 1, FB_H - 1, 24'hFFFFFF, 24'hFFFFFF);
        send_access(efb_pfs_pkg::REQ_READ, 0, 0, 24'h000000, 24'hFFFFFF);
        send_access(efb_pfs_pkg::REQ_READ, FB_W - 1, FB_H - 1, 24'hFFFFFF, 24'h000000);
        send_access(efb_pfs_pkg::REQ_WRITE, FB_W, 0, 24'h123456, 24'h654321);
        send_access(efb_pfs_pkg::REQ_READ, 0, FB_H, 24'h000000, 24'h000000);
        send_access(efb_pfs_pkg::REQ_READ, COORD_MAX, COORD_MAX, 24'hFFFFFF, 24'hFFFFFF);
    endtask

    // Short write and read sequences for RGBA6, RGB565, Z24, YUV4 and YUV7, with the
    // half-height frame and 16-bit depth of RGB565 and the ignored writes of YUV formats.
    task automatic test_format_corners();
        set_format(efb_pfs_pkg::FMT_RGBA6_Z24);
        send_access(efb_pfs_pkg::REQ_WRITE, 1, 1, 24'hA53CF0, 24'h123456);
        send_access(efb_pfs_pkg::REQ_READ, 1, 1, 24'h000000, 24'h000000);

        set_format(efb_pfs_pkg::FMT_RGB565_Z16);
        send_access(efb_pfs_pkg::REQ_WRITE, FB_W - 1, FB_H_HALF - 1, 24'h5AC37E, 24'hABCDEF);
        send_access(efb_pfs_pkg::REQ_READ, FB_W - 1, FB_H_HALF - 1, 24'h000000, 24'h000000);
        // Written under the full-height format but now below the active rows.
        send_access(efb_pfs_pkg::REQ_READ, FB_W - 1, FB_H - 1, 24'h000000, 24'h000000);

        set_format(efb_pfs_pkg::FMT_Z24);
        send_access(efb_pfs_pkg::REQ_WRITE, 2, 2, 24'hFFFFFF, 24'h00FF00);
        send_access(efb_pfs_pkg::REQ_READ, 2, 2, 24'h000000, 24'h000000);
        // The low byte cleared by the 16-bit write shows up in a raw read.
        send_access(efb_pfs_pkg::REQ_READ, FB_W - 1, FB_H_HALF - 1, 24'h000000, 24'h000000);

        set_format(FMT_YUV4);
        send_access(efb_pfs_pkg::REQ_WRITE, 1, 1, 24'h777777, 24'h777777);
        send_access(efb_pfs_pkg::REQ_READ, 1, 1, 24'h000000, 24'h000000);

        set_format(FMT_YUV7);
        send_access(efb_pfs_pkg::REQ_READ, FB_W - 1, FB_H_HALF - 1, 24'h000000, 24'h000000);
        send_access(efb_pfs_pkg::REQ_WRITE, 0, 0, 24'hFFFFFF, 24'hFFFFFF);
    endtask

    // Random traffic in phases, each under its own format setting.
    task automatic test_random_traffic();
        logic [efb_pfs_pkg::FMT_BITS-1:0] plan[$];
        int unsigned                      goal;
        plan = '{efb_pfs_pkg::FMT_RGB8_Z24, FMT_YUV7, efb_pfs_pkg::FMT_RGBA6_Z24,
                 efb_pfs_pkg::FMT_RGB565_Z16, efb_pfs_pkg::FMT_Z24, FMT_YUV4,
                 efb_pfs_pkg::FMT_RGB565_Z16, efb_pfs_pkg::FMT_RGB8_Z24, FMT_YUV5,
                 efb_pfs_pkg::FMT_RGBA6_Z24, efb_pfs_pkg::FMT_Z24, FMT_YUV6,
                 efb_pfs_pkg::FMT_RGB565_Z16};
        foreach (plan[i]) begin
            set_format(plan[i]);
            goal = stored_words + read_words + PHASE_WORDS;
            while (stored_words + read_words < goal)
                send_word(random_access());
        end
    endtask

    // Full-rate stretch: the sender never pauses and the receiver never stalls.
    task automatic test_streaming();
        int unsigned goal;
        set_format(efb_pfs_pkg::FMT_RGB8_Z24);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        goal = stored_words + read_words + PHASE_WORDS;
        while (stored_words + read_words < goal)
            send_word(random_access());
        wait_drained();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    // Every accepted result word is compared with the oldest expected answer.
    always @(posedge clk) begin : result_check
        efb_pfs_pkg::t_efb_out want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (answer_q.size() == 0) begin
                $error("result word with no answer pending: depth_out %h status %0d",
                       out_word.depth_out, out_word.status);
                errors++;
            end else begin
                want = answer_q.pop_front();
                if (out_word.depth_out !== want.depth_out) begin
                    $error("depth_out: expected %h, got %h", want.depth_out,
                           out_word.depth_out);
                    errors++;
                end
                if (out_word.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_word.status);
                    errors++;
                end
            end
        end
    end

    // Reset first, then the tests in order, then a drain and the verdict.
    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_format();
        test_format_corners();
        test_random_traffic();
        test_streaming();
        wait_drained();
        // Extra cycles catch any result word beyond the expected ones.
        repeat (8) @(posedge clk);
        $display("Covered %0d stored writes, %0d frame reads, %0d words outside the frame",
                 stored_words, read_words, outside_words);
        $display("and %0d dropped writes over %0d format settings; %0d words checked.",
                 dropped_writes, format_writes, results_seen);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/efb_pfs_pkg.sv
hw/rtl/efb_pixel_format_store_top.sv
sim/tb.sv
